>>> hdl/third_order_highpass_iir_unit_defines.svh
// Assertion macros for the third-order high-pass IIR unit.
// Included by the top level only; no other dependencies.
`ifndef THIRD_ORDER_HIGHPASS_IIR_UNIT_DEFINES_SVH
`define THIRD_ORDER_HIGHPASS_IIR_UNIT_DEFINES_SVH

// Same-cycle implication, checking suspended while reset is held
`define TOHP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checking suspended while reset is held
`define TOHP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/tohp_pkg.sv
// Package for the third-order high-pass IIR unit: widths, register indexes,
// microcode word format and the microcode program. No dependencies.
`default_nettype none

package tohp_pkg;

    // Data widths
    localparam int SAMPLE_BITS    = 16;
    localparam int COEF_FRAC_BITS = 20;
    localparam int Y_FRAC         = 4;
    localparam int GAIN_FRAC      = 12;
    localparam int GAIN_W         = 16;
    localparam int COEF_W         = 24;
    localparam int Y_W            = SAMPLE_BITS + Y_FRAC;
    localparam int PROD_W         = COEF_W + Y_W;
    localparam int ACC_W          = PROD_W + 3;
    localparam int TDATA_W        = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int CFG_IDX_W      = 3;
    localparam int STEP_W         = 4;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN = 3'd0,
        REG_B0   = 3'd1,
        REG_B2   = 3'd2,
        REG_A1   = 3'd3,
        REG_A2   = 3'd4,
        REG_A3   = 3'd5
    } t_reg_idx;

    // Reset values of the gain, b0 and b2 registers
    localparam logic [GAIN_W-1:0]        GAIN_RST = 16'd4096;
    localparam logic signed [COEF_W-1:0] B0_RST   = 24'sd1048576;
    localparam logic signed [COEF_W-1:0] B2_RST   = 24'sd3145728;

    // Multiplier operand pair selection
    typedef enum logic [2:0] {
        OPND_NONE,
        OPND_GAIN,
        OPND_B0,
        OPND_B2,
        OPND_A1,
        OPND_A2,
        OPND_A3
    } t_opnd;

    // Accumulator operation on the registered product
    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_CLR,
        ACC_ADD_SH,
        ACC_SUB
    } t_acc_op;

    // Jump condition
    typedef enum logic [1:0] {
        COND_NEXT,
        COND_WAIT_IN,
        COND_WAIT_OUT
    } t_cond;

    typedef logic [STEP_W-1:0] t_step;

    typedef struct packed {
        t_opnd   opnd;
        t_acc_op acc_op;
        logic    ld_x;
        logic    ld_y;
        logic    emit;
        t_cond   cond;
        t_step   jmp;
    } t_uword;

    // Program addresses
    localparam t_step STEP_IN    = 4'd0;
    localparam t_step STEP_X     = 4'd1;
    localparam t_step STEP_MB0   = 4'd2;
    localparam t_step STEP_MB2   = 4'd3;
    localparam t_step STEP_MA1   = 4'd4;
    localparam t_step STEP_MA2   = 4'd5;
    localparam t_step STEP_MA3   = 4'd6;
    localparam t_step STEP_LAST  = 4'd7;
    localparam t_step STEP_Y     = 4'd8;
    localparam t_step STEP_EMIT  = 4'd9;

    function automatic t_uword uw(input t_opnd o, input t_acc_op a, input logic lx,
                                  input logic ly, input logic em, input t_cond c,
                                  input t_step j);
        uw = '{opnd: o, acc_op: a, ld_x: lx, ld_y: ly, emit: em, cond: c, jmp: j};
    endfunction

    // Microcode ROM
    function automatic t_uword ucode(input t_step step);
        unique case (step)
            STEP_IN:   ucode = uw(OPND_GAIN, ACC_HOLD,   1'b0, 1'b0, 1'b0,
                                  COND_WAIT_IN, STEP_X);
            STEP_X:    ucode = uw(OPND_NONE, ACC_CLR,    1'b1, 1'b0, 1'b0,
                                  COND_NEXT, STEP_MB0);
            STEP_MB0:  ucode = uw(OPND_B0,   ACC_HOLD,   1'b0, 1'b0, 1'b0,
                                  COND_NEXT, STEP_MB2);
            STEP_MB2:  ucode = uw(OPND_B2,   ACC_ADD_SH, 1'b0, 1'b0, 1'b0,
                                  COND_NEXT, STEP_MA1);
            STEP_MA1:  ucode = uw(OPND_A1,   ACC_ADD_SH, 1'b0, 1'b0, 1'b0,
                                  COND_NEXT, STEP_MA2);
            STEP_MA2:  ucode = uw(OPND_A2,   ACC_SUB,    1'b0, 1'b0, 1'b0,
                                  COND_NEXT, STEP_MA3);
            STEP_MA3:  ucode = uw(OPND_A3,   ACC_SUB,    1'b0, 1'b0, 1'b0,
                                  COND_NEXT, STEP_LAST);
            STEP_LAST: ucode = uw(OPND_NONE, ACC_SUB,    1'b0, 1'b0, 1'b0,
                                  COND_NEXT, STEP_Y);
            STEP_Y:    ucode = uw(OPND_NONE, ACC_HOLD,   1'b0, 1'b1, 1'b0,
                                  COND_NEXT, STEP_EMIT);
            STEP_EMIT: ucode = uw(OPND_NONE, ACC_HOLD,   1'b0, 1'b0, 1'b1,
                                  COND_WAIT_OUT, STEP_IN);
            default:   ucode = uw(OPND_NONE, ACC_HOLD,   1'b0, 1'b0, 1'b0,
                                  COND_NEXT, STEP_IN);
        endcase
    endfunction

endpackage

`default_nettype wire

>>> hdl/third_order_highpass_iir_unit.sv
// Third-order high-pass IIR unit (direct form I, fixed point) with input gain.
// One multiply-accumulate datapath run by a microcode ROM from tohp_pkg.
// Usage:
//   Input stream  s_axis_*: one signed audio sample per transfer.
//   Output stream m_axis_*: one filtered sample per input, tuser = clip flag.
//   Config port: i_cfg_wr_en / i_cfg_idx / i_cfg_data, written while idle;
//     index 0 gain (Q4.12), 1 b0, 2 b2, 3 a1, 4 a2, 5 a3 (Q3.20); others ignored.
// Timing:
//   The ten-step program (gain multiply, gain rounding, five coefficient
//   multiplies through the single multiplier, accumulate drain, output
//   rounding, emit) runs once per sample and waits for the input transfer
//   at its first step; the result is registered for m_axis at the emit step.
//   s_axis_tready is high only at the program's first step.
// Reset (i_rst_n low, synchronous): histories cleared, registers to defaults
//   (unity gain, b0 = 1.0, b2 = 3.0, feedback 0), output register empty.
// Back-pressure: the output register holds one result; the next sample is
//   accepted while it waits, and the program waits at its emit step until
//   the register is taken.
`default_nettype none

`include "third_order_highpass_iir_unit_defines.svh"

module third_order_highpass_iir_unit
    import tohp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Input stream
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [TDATA_W-1:0] s_axis_tdata,   // [15:0] sample_in
    // Output stream
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [TDATA_W-1:0]      m_axis_tdata,   // [15:0] sample_out
    output logic                    m_axis_tuser,   // [0] clipped
    // Configuration write port
    input  wire logic               i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [COEF_W-1:0]  i_cfg_data
);

    // Rounding offsets and saturation limits
    localparam logic signed [PROD_W-1:0] GAIN_RND = PROD_W'(64'sd1 <<< (GAIN_FRAC - 1));
    localparam logic signed [PROD_W-1:0] X_MAX    =
        PROD_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [PROD_W-1:0] X_MIN    = PROD_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));
    localparam logic signed [ACC_W-1:0]  ACC_RND  =
        ACC_W'(64'sd1 <<< (COEF_FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0]  Y_MAX    = ACC_W'((64'sd1 <<< (Y_W - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0]  Y_MIN    = ACC_W'(-(64'sd1 <<< (Y_W - 1)));
    localparam logic signed [Y_W:0]      O_RND    = (Y_W + 1)'(64'sd1 <<< (Y_FRAC - 1));
    localparam logic signed [Y_W:0]      O_MAX    =
        (Y_W + 1)'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [Y_W:0]      O_MIN    = (Y_W + 1)'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

    // Configuration registers
    logic [GAIN_W-1:0]        r_gain;
    logic signed [COEF_W-1:0] r_b0, r_b2, r_a1, r_a2, r_a3;

    // Sequencer and datapath
    t_step                    r_step, n_step;
    t_uword                   w_uw;
    logic                     w_adv;
    logic                     w_in_xfer;
    logic                     w_slot_free;
    logic signed [COEF_W-1:0] w_opa;
    logic signed [Y_W-1:0]    w_opb;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [SAMPLE_BITS-1:0] r_xh [3];
    logic signed [Y_W-1:0]    r_yh [3];
    logic signed [Y_W-1:0]    r_y;
    logic                     r_clip;

    // Rounding and saturation
    logic signed [PROD_W-1:0]      w_gain_sh;
    logic signed [SAMPLE_BITS-1:0] w_x;
    logic                          w_x_clip;
    logic signed [ACC_W-1:0]       w_acc_sh;
    logic signed [Y_W-1:0]         w_y;
    logic                          w_y_clip;
    logic signed [Y_W:0]           w_o_sh;
    logic signed [SAMPLE_BITS-1:0] w_o;
    logic                          w_o_clip;

    // Output register
    logic                    r_out_valid;
    logic [SAMPLE_BITS-1:0]  r_out_data;
    logic                    r_out_clip;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RST;
            r_b0   <= B0_RST;
            r_b2   <= B2_RST;
            r_a1   <= '0;
            r_a2   <= '0;
            r_a3   <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_GAIN: r_gain <= i_cfg_data[GAIN_W-1:0];
                REG_B0:   r_b0   <= i_cfg_data;
                REG_B2:   r_b2   <= i_cfg_data;
                REG_A1:   r_a1   <= i_cfg_data;
                REG_A2:   r_a2   <= i_cfg_data;
                REG_A3:   r_a3   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Control word fetch and jump decision
    assign w_uw          = ucode(r_step);
    assign s_axis_tready = (r_step == STEP_IN);
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign w_slot_free   = !r_out_valid || m_axis_tready;

    always_comb begin
        unique case (w_uw.cond)
            COND_NEXT:     w_adv = 1'b1;
            COND_WAIT_IN:  w_adv = w_in_xfer;
            COND_WAIT_OUT: w_adv = w_slot_free;
            default:       w_adv = 1'b1;
        endcase
        n_step = w_adv ? w_uw.jmp : r_step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IN;
        end else begin
            r_step <= n_step;
        end
    end

    // Multiplier operand selection
    always_comb begin
        unique case (w_uw.opnd)
            OPND_GAIN: begin
                w_opa = {{(COEF_W - GAIN_W){1'b0}}, r_gain};
                w_opb = {{(Y_W - SAMPLE_BITS){s_axis_tdata[SAMPLE_BITS-1]}},
                         s_axis_tdata[SAMPLE_BITS-1:0]};
            end
            OPND_B0: begin
                w_opa = r_b0;
                w_opb = {{(Y_W - SAMPLE_BITS){r_x[SAMPLE_BITS-1]}}, r_x}
                      - {{(Y_W - SAMPLE_BITS){r_xh[2][SAMPLE_BITS-1]}}, r_xh[2]};
            end
            OPND_B2: begin
                w_opa = r_b2;
                w_opb = {{(Y_W - SAMPLE_BITS){r_xh[1][SAMPLE_BITS-1]}}, r_xh[1]}
                      - {{(Y_W - SAMPLE_BITS){r_xh[0][SAMPLE_BITS-1]}}, r_xh[0]};
            end
            OPND_A1: begin
                w_opa = r_a1;
                w_opb = r_yh[0];
            end
            OPND_A2: begin
                w_opa = r_a2;
                w_opb = r_yh[1];
            end
            OPND_A3: begin
                w_opa = r_a3;
                w_opb = r_yh[2];
            end
            default: begin
                w_opa = '0;
                w_opb = '0;
            end
        endcase
    end

    // Signed multiply, both operands sign-extended to the product width
    assign w_prod = w_opa * w_opb;

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
    end

    // Accumulator; numerator terms are scaled up to the Q.4 feedback scale
    always_ff @(posedge i_clk) begin
        unique case (w_uw.acc_op)
            ACC_CLR:    r_acc <= '0;
            ACC_ADD_SH: r_acc <= r_acc + (ACC_W'(r_prod) <<< Y_FRAC);
            ACC_SUB:    r_acc <= r_acc - ACC_W'(r_prod);
            default:    r_acc <= r_acc;
        endcase
    end

    // Gain rounding and saturation
    always_comb begin
        w_gain_sh = (r_prod + GAIN_RND) >>> GAIN_FRAC;
        w_x_clip  = (w_gain_sh > X_MAX) || (w_gain_sh < X_MIN);
        if (w_gain_sh > X_MAX) begin
            w_x = X_MAX[SAMPLE_BITS-1:0];
        end else if (w_gain_sh < X_MIN) begin
            w_x = X_MIN[SAMPLE_BITS-1:0];
        end else begin
            w_x = w_gain_sh[SAMPLE_BITS-1:0];
        end
    end

    // Internal y rounding (half up) and saturation
    always_comb begin
        w_acc_sh = (r_acc + ACC_RND) >>> COEF_FRAC_BITS;
        w_y_clip = (w_acc_sh > Y_MAX) || (w_acc_sh < Y_MIN);
        if (w_acc_sh > Y_MAX) begin
            w_y = Y_MAX[Y_W-1:0];
        end else if (w_acc_sh < Y_MIN) begin
            w_y = Y_MIN[Y_W-1:0];
        end else begin
            w_y = w_acc_sh[Y_W-1:0];
        end
    end

    // Output rounding to an integer sample and saturation
    always_comb begin
        w_o_sh   = ($signed({r_y[Y_W-1], r_y}) + O_RND) >>> Y_FRAC;
        w_o_clip = (w_o_sh > O_MAX) || (w_o_sh < O_MIN);
        if (w_o_sh > O_MAX) begin
            w_o = O_MAX[SAMPLE_BITS-1:0];
        end else if (w_o_sh < O_MIN) begin
            w_o = O_MIN[SAMPLE_BITS-1:0];
        end else begin
            w_o = w_o_sh[SAMPLE_BITS-1:0];
        end
    end

    // Scaled input, histories and clip flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x    <= '0;
            r_y    <= '0;
            r_clip <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_xh[i] <= '0;
                r_yh[i] <= '0;
            end
        end else begin
            if (w_in_xfer) begin
                r_clip <= 1'b0;
            end else if (w_uw.ld_x) begin
                r_clip <= r_clip | w_x_clip;
            end else if (w_uw.ld_y) begin
                r_clip <= r_clip | w_y_clip;
            end
            if (w_uw.ld_x) begin
                r_x <= w_x;
            end
            if (w_uw.ld_y) begin
                r_y     <= w_y;
                r_yh[2] <= r_yh[1];
                r_yh[1] <= r_yh[0];
                r_yh[0] <= w_y;
                r_xh[2] <= r_xh[1];
                r_xh[1] <= r_xh[0];
                r_xh[0] <= r_x;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_uw.emit && w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_uw.emit && w_adv) begin
            r_out_data <= w_o;
            r_out_clip <= r_clip | w_o_clip;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TDATA_W'(r_out_data);
    assign m_axis_tuser  = r_out_clip;

    // Checks
    `TOHP_ASSERT_NXT(a_xfer_starts_prog, i_clk, i_rst_n, w_in_xfer, r_step == STEP_X, "input transfer did not start the program")
    `TOHP_ASSERT_NXT(a_emit_waits, i_clk, i_rst_n, (r_step == STEP_EMIT) && r_out_valid && !m_axis_tready, (r_step == STEP_EMIT) && r_out_valid, "emit step left while output register full")
    `TOHP_ASSERT_IMP(a_step_range, i_clk, i_rst_n, 1'b1, r_step <= STEP_EMIT, "step counter outside the program")

endmodule

`default_nettype wire

>>> tb/third_order_highpass_iir_unit_tb.sv
// Self-checking testbench for third_order_highpass_iir_unit: drives samples and
// register writes, predicts each filtered sample and clip flag, and compares them.
// Depends on tohp_pkg and the unit itself.
`timescale 1ns / 1ps

module third_order_highpass_iir_unit_tb;
    import tohp_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 16;
    localparam int ITEMS_PER_BLOCK = 110;

    // Indexes past the register file, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam logic [COEF_W-1:0] COEF_MAX = 24'h7FFFFF;
    localparam logic [COEF_W-1:0] COEF_MIN = 24'h800000;
    localparam logic [COEF_W-1:0] COEF_ZERO = 24'h000000;

    // Stable third-order high-pass, cut-off near a tenth of the sample rate
    localparam logic signed [COEF_W-1:0] HP_B0 = 24'sd557950;
    localparam logic signed [COEF_W-1:0] HP_B2 = 24'sd1673850;
    localparam logic signed [COEF_W-1:0] HP_A1 = -24'sd1845494;
    localparam logic signed [COEF_W-1:0] HP_A2 = 24'sd1240386;
    localparam logic signed [COEF_W-1:0] HP_A3 = -24'sd291612;

    typedef enum {
        SET_DEFAULT,
        SET_HIGHPASS,
        SET_RANDOM,
        SET_EXTREME,
        SET_MILD
    } t_setting_kind;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   clipped;
    } t_filt_result;

    // Filter predictor: own copy of registers and histories, queue of
    // outputs still owed by the unit
    class highpass_tracker;
        logic [GAIN_W-1:0]        gain;
        logic signed [COEF_W-1:0] b0, b2, a1, a2, a3;
        longint                   x_hist[3];
        longint                   y_hist[3];
        t_filt_result             owed_q[$];
        int unsigned              mismatches;

        function new();
            gain = GAIN_RST;
            b0   = B0_RST;
            b2   = B2_RST;
            a1   = '0;
            a2   = '0;
            a3   = '0;
            foreach (x_hist[i]) begin
                x_hist[i] = 0;
                y_hist[i] = 0;
            end
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
            case (idx)
                REG_GAIN: gain = val[GAIN_W-1:0];
                REG_B0:   b0 = val;
                REG_B2:   b2 = val;
                REG_A1:   a1 = val;
                REG_A2:   a2 = val;
                REG_A3:   a3 = val;
                default: ;
            endcase
        endfunction

        function longint clamp(longint v, int w, inout bit clip);
            longint hi, lo;
            hi = (longint'(1) <<< (w - 1)) - 1;
            lo = -hi - 1;
            if (v > hi) begin
                clip = 1'b1;
                return hi;
            end
            if (v < lo) begin
                clip = 1'b1;
                return lo;
            end
            return v;
        endfunction

        // One accepted input transfer: gain, filter step, rounding
        function void take_sample(logic [SAMPLE_BITS-1:0] raw);
            longint       smp, xs, acc, yi, oi;
            bit           clip;
            t_filt_result want;
            clip = 1'b0;
            smp  = longint'($signed(raw));
            xs   = (smp * longint'(gain) + (longint'(1) <<< (GAIN_FRAC - 1))) >>> GAIN_FRAC;
            xs   = clamp(xs, SAMPLE_BITS, clip);
            // numerator terms lifted by 16 to line up with the Q.4 feedback
            acc = longint'(b0) * (xs - x_hist[2]) * 16
                + longint'(b2) * (x_hist[1] - x_hist[0]) * 16
                - longint'(a1) * y_hist[0]
                - longint'(a2) * y_hist[1]
                - longint'(a3) * y_hist[2];
            yi = (acc + (longint'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
            yi = clamp(yi, Y_W, clip);
            oi = (yi + (longint'(1) <<< (Y_FRAC - 1))) >>> Y_FRAC;
            oi = clamp(oi, SAMPLE_BITS, clip);
            x_hist[2] = x_hist[1];
            x_hist[1] = x_hist[0];
            x_hist[0] = xs;
            y_hist[2] = y_hist[1];
            y_hist[1] = y_hist[0];
            y_hist[0] = yi;
            want.sample  = oi[SAMPLE_BITS-1:0];
            want.clipped = clip;
            owed_q.push_back(want);
        endfunction

        // One accepted output transfer against the oldest owed result
        function void check_output(logic [TDATA_W-1:0] data, logic clip_flag);
            t_filt_result want;
            if (owed_q.size() == 0) begin
                $display("%0t: unexpected output, actual sample_out %0d clipped %b",
                         $time, $signed(data[SAMPLE_BITS-1:0]), clip_flag);
                mismatches++;
                return;
            end
            want = owed_q.pop_front();
            if (data[SAMPLE_BITS-1:0] !== want.sample) begin
                $display("%0t: sample_out mismatch, expected %0d, actual %0d", $time,
                         $signed(want.sample), $signed(data[SAMPLE_BITS-1:0]));
                mismatches++;
            end
            if (clip_flag !== want.clipped) begin
                $display("%0t: clipped mismatch, expected %b, actual %b", $time,
                         want.clipped, clip_flag);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return owed_q.size();
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [TDATA_W-1:0]     s_axis_tdata = '0;      // [15:0] sample_in
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]     m_axis_tdata;           // [15:0] sample_out
    logic                   m_axis_tuser;           // [0] clipped
    logic                   i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [COEF_W-1:0]      i_cfg_data = '0;

    highpass_tracker        tracker;
    int unsigned            tx_idle_pct = 0;
    int unsigned            rx_idle_pct = 0;
    int unsigned            quiet_cycles = 0;
    logic [SAMPLE_BITS-1:0] prev_smp = '0;

    third_order_highpass_iir_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Receiver back-pressure
    always @(posedge i_clk) begin
        m_axis_tready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
    end

    // Transfer monitor: outputs checked, inputs fed to the predictor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                tracker.check_output(m_axis_tdata, m_axis_tuser);
            if (s_axis_tvalid && s_axis_tready)
                tracker.take_sample(s_axis_tdata[SAMPLE_BITS-1:0]);
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("third_order_highpass_iir_unit regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one sample, with random idle cycles ahead of it
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] smp);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Hold off input until every owed output is back and the unit is idle
    task automatic drain_outputs();
        s_axis_tvalid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write enable left high, the caller lowers it after a burst
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        tracker.write_reg(idx, val);
    endtask

    task automatic apply_config(input logic [GAIN_W-1:0] g, input logic [COEF_W-1:0] c_b0,
                                input logic [COEF_W-1:0] c_b2, input logic [COEF_W-1:0] c_a1,
                                input logic [COEF_W-1:0] c_a2, input logic [COEF_W-1:0] c_a3);
        logic [COEF_W-GAIN_W-1:0] pad;
        pad = (COEF_W - GAIN_W)'($urandom());
        write_reg(REG_GAIN, {pad, g});
        write_reg(REG_B0, c_b0);
        write_reg(REG_B2, c_b2);
        write_reg(REG_A1, c_a1);
        write_reg(REG_A2, c_a2);
        write_reg(REG_A3, c_a3);
        write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, COEF_W'($urandom()));
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic load_setting(input t_setting_kind kind);
        logic [GAIN_W-1:0] g;
        logic [COEF_W-1:0] c0, c2, c3, c4, c5;
        case (kind)
            SET_DEFAULT: begin
                g  = GAIN_RST;
                c0 = B0_RST;
                c2 = B2_RST;
                c3 = COEF_ZERO;
                c4 = COEF_ZERO;
                c5 = COEF_ZERO;
            end
            SET_HIGHPASS: begin
                g  = GAIN_W'($urandom_range(8192, 2048));
                c0 = HP_B0;
                c2 = HP_B2;
                c3 = HP_A1;
                c4 = HP_A2;
                c5 = HP_A3;
            end
            SET_RANDOM: begin
                g  = GAIN_W'($urandom());
                c0 = COEF_W'($urandom());
                c2 = COEF_W'($urandom());
                c3 = COEF_W'($urandom());
                c4 = COEF_W'($urandom());
                c5 = COEF_W'($urandom());
            end
            SET_EXTREME: begin
                g  = $urandom_range(1) ? 16'hFFFF : 16'h0001;
                c0 = $urandom_range(1) ? COEF_MAX : COEF_MIN;
                c2 = $urandom_range(1) ? COEF_MAX : COEF_MIN;
                c3 = $urandom_range(1) ? COEF_MAX : COEF_MIN;
                c4 = $urandom_range(1) ? COEF_MAX : COEF_MIN;
                c5 = $urandom_range(1) ? COEF_MAX : COEF_MIN;
            end
            default: begin
                // small feedback keeps the loop stable
                g  = GAIN_W'($urandom());
                c0 = COEF_W'(int'($urandom_range(1 << 20)) - (1 << 19));
                c2 = COEF_W'(int'($urandom_range(1 << 21)) - (1 << 20));
                c3 = COEF_W'(int'($urandom_range(1 << 19)) - (1 << 18));
                c4 = COEF_W'(int'($urandom_range(1 << 19)) - (1 << 18));
                c5 = COEF_W'(int'($urandom_range(1 << 19)) - (1 << 18));
            end
        endcase
        apply_config(g, c0, c2, c3, c4, c5);
    endtask

    // Mix of full-range noise, quiet signal and slow drift
    function automatic logic [SAMPLE_BITS-1:0] random_sample();
        int unsigned pick;
        int          v;
        pick = $urandom_range(99);
        if (pick < 45) begin
            prev_smp = SAMPLE_BITS'($urandom());
        end else if (pick < 70) begin
            v = int'($urandom_range(511)) - 256;
            prev_smp = v[SAMPLE_BITS-1:0];
        end else begin
            v = int'($signed(prev_smp)) + int'($urandom_range(4095)) - 2048;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            prev_smp = v[SAMPLE_BITS-1:0];
        end
        return prev_smp;
    endfunction

    initial begin
        tracker = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: rails, single steps and alternating bit patterns
        send_sample(16'h0000);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h0001);
        send_sample(16'hFFFF);
        send_sample(16'h5555);
        send_sample(16'hAAAA);
        send_sample(16'h0000);

        // Full gain and coefficients at their limits: clipping at every stage
        drain_outputs();
        apply_config(16'hFFFF, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h0064);
        send_sample(16'h0000);
        send_sample(16'hFFFF);

        // Zero gain, feedback alone drives the output
        drain_outputs();
        apply_config(16'h0000, B0_RST, B2_RST, COEF_MIN, COEF_MAX, COEF_MIN);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h0000);

        // Writes to the unused indexes must leave the high-pass untouched
        drain_outputs();
        apply_config(GAIN_RST, HP_B0, HP_B2, HP_A1, HP_A2, HP_A3);
        @(posedge i_clk);
        write_reg(REG_SPARE_LO, {COEF_W{1'b1}});
        write_reg(REG_SPARE_HI, COEF_ZERO);
        i_cfg_wr_en <= 1'b0;
        send_sample(16'h7FFF);
        send_sample(16'h0000);
        send_sample(16'h0000);
        send_sample(16'h8000);
        send_sample(16'h0000);
        send_sample(16'h0000);

        // Random part: three idle patterns, each across every kind of setting
        for (int ph = 0; ph < 3; ph++) begin
            for (int blk = 0; blk < 5; blk++) begin
                drain_outputs();
                case (ph)
                    0: begin
                        tx_idle_pct = 12;
                        rx_idle_pct = 52;
                    end
                    1: begin
                        tx_idle_pct = 52;
                        rx_idle_pct = 12;
                    end
                    default: begin
                        tx_idle_pct = 0;
                        rx_idle_pct = 0;
                    end
                endcase
                load_setting(t_setting_kind'(blk));
                repeat (ITEMS_PER_BLOCK) send_sample(random_sample());
            end
        end

        drain_outputs();
        if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
            $display("third_order_highpass_iir_unit regression: pass");
        end else begin
            $display("third_order_highpass_iir_unit regression: fail");
        end
        $finish;
    end

endmodule
